/* hw/rtl/evcp_pkg.sv */
// Shared types, constants and the duty table of the charge pilot controller.
`default_nettype none

package evcp_pkg;

  // Payload field widths.
  localparam int unsigned PilotW   = 3;
  localparam int unsigned CableW   = 2;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DutyW    = 7;
  localparam int unsigned StateW   = 3;

  // Configuration register widths and port layout.
  localparam int unsigned AmpsW    = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CfgMaxAmps = cfg_idx_t'(0);
  localparam cfg_idx_t CfgOutdoor = cfg_idx_t'(1);
  localparam cfg_idx_t CfgTimeout = cfg_idx_t'(2);

  // Configuration reset values.
  localparam logic [AmpsW-1:0]    MaxAmpsRst = AmpsW'(16);
  localparam logic [TimeoutW-1:0] TimeoutRst = TimeoutW'(5000);

  // Classified pilot levels; every other code is a fault.
  typedef logic [PilotW-1:0] pilot_t;
  localparam pilot_t PilotLv12 = pilot_t'(0);
  localparam pilot_t PilotLv9  = pilot_t'(1);
  localparam pilot_t PilotLv6  = pilot_t'(2);
  localparam pilot_t PilotLv3  = pilot_t'(3);

  // Cable classes; every other code means no cable coding.
  typedef logic [CableW-1:0] cable_t;
  localparam cable_t Cable13A = cable_t'(0);
  localparam cable_t Cable20A = cable_t'(1);

  // Current limits in amperes.
  localparam int unsigned CapAmps13  = 13;
  localparam int unsigned CapAmps20  = 20;
  localparam int unsigned CapAmps32  = 32;
  localparam int unsigned MinAmps    = 6;
  localparam int unsigned FloorAmps  = 4;
  localparam int unsigned AmpsIdxW   = $clog2(CapAmps32 + 1);

  // Duty arithmetic constants.
  localparam int unsigned DutyMul    = 1540;
  localparam int unsigned DutyOfs    = 1500;
  localparam int unsigned DutyDiv    = 1000;
  localparam int unsigned DutyLowLim = 10;
  localparam logic [DutyW-1:0] DutyHigh = DutyW'(100);

  typedef logic [DutyW-1:0] duty_lut_t [0:CapAmps32];

  // Duty percent for every announced current, built at elaboration.
  function automatic duty_lut_t build_duty_lut();
    duty_lut_t lut;
    for (int i = 0; i <= CapAmps32; i++) begin
      lut[i] = DutyW'((DutyMul * i + DutyOfs) / DutyDiv);
    end
    return lut;
  endfunction

  localparam duty_lut_t DutyLut = build_duty_lut();

endpackage

`default_nettype wire

/* hw/rtl/evcp_in_if.sv */
// Valid/ready channel that carries one pilot tick.
`default_nettype none

interface evcp_in_if;
  logic                         valid;
  logic                         ready;
  logic [evcp_pkg::PilotW-1:0]  pilot_level;
  logic [evcp_pkg::CableW-1:0]  cable_limit;
  logic [evcp_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, output pilot_level, output cable_limit, output now_ms,
                  input ready);
  modport sink (input valid, input pilot_level, input cable_limit, input now_ms,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/evcp_out_if.sv */
// Valid/ready channel that carries one pilot controller result.
`default_nettype none

interface evcp_out_if;
  logic                         valid;
  logic                         ready;
  logic [evcp_pkg::DutyW-1:0]   duty_percent;
  logic                         contactor_closed;
  logic [evcp_pkg::StateW-1:0]  station_state;

  modport source (output valid, output duty_percent, output contactor_closed,
                  output station_state, input ready);
  modport sink (input valid, input duty_percent, input contactor_closed,
                input station_state, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ev_charge_pilot_state_machine.sv */
// Control pilot state machine of an EV charge point: top level.
`default_nettype none

// Channel   Dir  Payload                                        Beat taken when
// in_if     in   pilot_level, cable_limit, now_ms               valid && ready
// out_if    out  duty_percent, contactor_closed, station_state  valid && ready
// cfg       in   cfg_idx_i, cfg_wdata_i                         cfg_we_i
//
// A beat is captured in the input register and its result is registered in the
// output register once that register is free or drains; the sustained rate is
// one beat per cycle while the output side does not stall. The charger state and
// timer update in the same edge that moves a beat into the output register. The
// input side stays ready while the output register holds a waiting result, as
// long as the input register can move on. Reset returns to state A with the timer
// idle and the configuration registers at their defaults.

module ev_charge_pilot_state_machine (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire evcp_pkg::cfg_idx_t        cfg_idx_i,
  input  wire logic [evcp_pkg::CfgDataW-1:0] cfg_wdata_i,
  evcp_in_if.sink                        in_if,
  evcp_out_if.source                     out_if
);
  import evcp_pkg::*;

  typedef enum logic [StateW-1:0] {
    StA = 3'd0,
    StB = 3'd1,
    StC = 3'd2,
    StD = 3'd3,
    StF = 3'd4
  } state_e;

  // Configuration registers.
  logic [AmpsW-1:0]    max_amps_q;
  logic                outdoor_q;
  logic [TimeoutW-1:0] timeout_q;

  // Charger state and the start time of a low duty period (zero when idle).
  state_e              state_q, state_d;
  logic [TimeW-1:0]    since_q, since_d;

  // Input register.
  logic                s1_valid_q;
  pilot_t              lvl_q;
  cable_t              cable_q;
  logic [TimeW-1:0]    now_q;

  // Output register.
  logic                out_valid_q;
  logic [DutyW-1:0]    duty_q, duty_d;
  logic                closed_q, closed_d;

  logic                s1_adv;
  logic [AmpsW-1:0]    cap;
  logic [AmpsW-1:0]    amps;
  logic [DutyW-1:0]    pct;
  logic                low_duty;
  logic [TimeW-1:0]    elapsed;
  logic                forced;

  // The input register moves on when the output register is free or drains.
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_amps_q <= MaxAmpsRst;
      outdoor_q  <= 1'b0;
      timeout_q  <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxAmps: max_amps_q <= cfg_wdata_i[AmpsW-1:0];
        CfgOutdoor: outdoor_q  <= cfg_wdata_i[0];
        CfgTimeout: timeout_q  <= cfg_wdata_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // Announced current: the user limit clamped by the cable class, with
  // anything under the minimum announced as the floor current.
  always_comb begin
    case (cable_q)
      Cable13A: cap = AmpsW'(CapAmps13);
      Cable20A: cap = AmpsW'(CapAmps20);
      default:  cap = AmpsW'(CapAmps32);
    endcase
    amps = (max_amps_q > cap) ? cap : max_amps_q;
    if (amps < AmpsW'(MinAmps)) begin
      amps = AmpsW'(FloorAmps);
    end
  end

  assign pct      = DutyLut[amps[AmpsIdxW-1:0]];
  assign low_duty = pct < DutyW'(DutyLowLim);
  assign elapsed  = now_q - since_q;

  // Next state, timer and outputs for the beat in the input register.
  always_comb begin
    state_d  = state_q;
    since_d  = since_q;
    duty_d   = DutyHigh;
    closed_d = 1'b0;
    forced   = 1'b0;
    case (state_q)
      StA: begin
        state_d = (low_duty || lvl_q == PilotLv12) ? StA : StB;
      end
      StB: begin
        case (lvl_q)
          PilotLv12: state_d = StA;
          PilotLv9:  duty_d = pct;
          PilotLv6: begin
            duty_d  = pct;
            state_d = StC;
          end
          PilotLv3: begin
            duty_d  = pct;
            state_d = StD;
          end
          default:   state_d = StF;
        endcase
      end
      StC, StD: begin
        // The low duty timer runs while the announced duty is under the
        // digital-communication threshold; a start at time zero stays idle.
        if (low_duty) begin
          if (since_q == '0) begin
            since_d = now_q;
          end else if (elapsed > TimeW'(timeout_q)) begin
            forced = 1'b1;
          end
        end else begin
          since_d = '0;
        end
        if (forced) begin
          state_d = StA;
          since_d = '0;
        end else begin
          case (lvl_q)
            PilotLv12: begin
              state_d = StA;
              since_d = '0;
            end
            PilotLv9: begin
              duty_d  = pct;
              state_d = StB;
              since_d = '0;
            end
            PilotLv6: begin
              duty_d   = pct;
              closed_d = 1'b1;
              state_d  = StC;
            end
            PilotLv3: begin
              // Ventilation requested: only an outdoor site may charge.
              if (outdoor_q) begin
                duty_d   = pct;
                closed_d = 1'b1;
              end
              state_d = StD;
            end
            default: begin
              state_d = StF;
              since_d = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = (lvl_q == PilotLv12) ? StA : StF;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StA;
      since_q     <= '0;
    end else begin
      if (in_if.ready) begin
        s1_valid_q <= in_if.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        since_q     <= since_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      lvl_q   <= in_if.pilot_level;
      cable_q <= in_if.cable_limit;
      now_q   <= in_if.now_ms;
    end
    if (s1_adv) begin
      duty_q   <= duty_d;
      closed_q <= closed_d;
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.duty_percent     = duty_q;
  assign out_if.contactor_closed = closed_q;
  assign out_if.station_state    = state_q;

  // The contactor is only closed while charging or ventilating.
  a_contactor_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.contactor_closed |->
      (out_if.station_state == StC || out_if.station_state == StD))
    else $error("contactor closed outside states C and D");

  // Duty is either steady high or a value from the current table.
  a_duty_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.duty_percent == DutyHigh ||
                      out_if.duty_percent <= DutyW'(CapAmps32 + 18)))
    else $error("duty percent out of range");

  // The low duty timer only runs in states C and D.
  a_timer_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    since_q != '0 |-> (state_q == StC || state_q == StD))
    else $error("low duty timer running outside states C and D");

  // An empty input register never stalls the input side.
  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_if.ready)
    else $error("input stalled with an empty input register");

endmodule

`default_nettype wire

/* sim/evcp_check_pkg.sv */
// Expected-result tracker for the charge pilot controller test bench.
`timescale 1ns / 1ps

package evcp_check_pkg;
  import evcp_pkg::*;

  // Charger states as they appear on station_state.
  typedef enum logic [StateW-1:0] {
    StA = 3'd0,
    StB = 3'd1,
    StC = 3'd2,
    StD = 3'd3,
    StF = 3'd4
  } station_e;

  // The one index that selects no register; writes to it are dropped.
  localparam cfg_idx_t CfgUnused = cfg_idx_t'(3);

  typedef struct packed {
    logic [DutyW-1:0]  duty;
    logic              closed;
    logic [StateW-1:0] st;
  } pilot_result_t;

  class pilot_scoreboard;
    logic [AmpsW-1:0]    max_amps;
    logic                outdoor;
    logic [TimeoutW-1:0] timeout_ms;
    logic [StateW-1:0]   state;
    logic [TimeW-1:0]    low_since;
    pilot_result_t       expected_q[$];
    int unsigned         errors;
    int unsigned         ticks;
    int unsigned         expiries;
    int unsigned         per_state[5];

    function new();
      max_amps   = MaxAmpsRst;
      outdoor    = 1'b0;
      timeout_ms = TimeoutRst;
      state      = StA;
      low_since  = '0;
      errors     = 0;
      ticks      = 0;
      expiries   = 0;
      foreach (per_state[i]) per_state[i] = 0;
    endfunction

    function void write_register(cfg_idx_t idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgMaxAmps: max_amps = data[AmpsW-1:0];
        CfgOutdoor: outdoor = data[0];
        CfgTimeout: timeout_ms = data[TimeoutW-1:0];
        default: ;
      endcase
    endfunction

    // Duty percent announced for the user limit after the cable clamp.
    function int unsigned announced_duty(cable_t cable);
      int unsigned amps;
      int unsigned cap;
      amps = max_amps;
      cap = CapAmps32;
      if (cable == Cable13A) cap = CapAmps13;
      else if (cable == Cable20A) cap = CapAmps20;
      if (amps > cap) amps = cap;
      if (amps < MinAmps) amps = FloorAmps;
      return (DutyMul * amps + DutyOfs) / DutyDiv;
    endfunction

    function void note_tick(pilot_t lvl, cable_t cable, logic [TimeW-1:0] now);
      int unsigned       pct;
      logic [TimeW-1:0]  elapsed;
      logic [DutyW-1:0]  duty;
      logic              closed;
      logic [StateW-1:0] st;
      bit                forced;
      pilot_result_t     res;
      pct = announced_duty(cable);
      duty = DutyHigh;
      closed = 1'b0;
      st = state;
      forced = 1'b0;
      case (st)
        StA: st = (pct < DutyLowLim || lvl == PilotLv12) ? StA : StB;
        StB: begin
          case (lvl)
            PilotLv12: st = StA;
            PilotLv9: duty = DutyW'(pct);
            PilotLv6: begin
              duty = DutyW'(pct);
              st = StC;
            end
            PilotLv3: begin
              duty = DutyW'(pct);
              st = StD;
            end
            default: st = StF;
          endcase
        end
        StC, StD: begin
          // The low-rate timer only runs while the duty is under the limit.
          if (pct < DutyLowLim) begin
            if (low_since == '0) begin
              low_since = now;
            end else begin
              elapsed = now - low_since;
              if (elapsed > TimeW'(timeout_ms)) forced = 1'b1;
            end
          end else begin
            low_since = '0;
          end
          if (forced) begin
            st = StA;
            low_since = '0;
            expiries++;
          end else begin
            case (lvl)
              PilotLv12: begin
                st = StA;
                low_since = '0;
              end
              PilotLv9: begin
                duty = DutyW'(pct);
                st = StB;
                low_since = '0;
              end
              PilotLv6: begin
                duty = DutyW'(pct);
                closed = 1'b1;
                st = StC;
              end
              PilotLv3: begin
                // Ventilation is only allowed for an outdoor charge point.
                if (outdoor) begin
                  duty = DutyW'(pct);
                  closed = 1'b1;
                end
                st = StD;
              end
              default: begin
                st = StF;
                low_since = '0;
              end
            endcase
          end
        end
        default: st = (lvl == PilotLv12) ? StA : StF;
      endcase
      state = st;
      res.duty = duty;
      res.closed = closed;
      res.st = st;
      expected_q.push_back(res);
      ticks++;
    endfunction

    function void check_result(logic [DutyW-1:0] duty, logic closed, logic [StateW-1:0] st);
      pilot_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result beat with no tick waiting: duty %0d contactor %0d state %0d",
               duty, closed, st);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (exp_res.st < 5) per_state[exp_res.st]++;
      if (duty !== exp_res.duty) begin
        $error("duty_percent: expected %0d, actual %0d", exp_res.duty, duty);
        errors++;
      end
      if (closed !== exp_res.closed) begin
        $error("contactor_closed: expected %0d, actual %0d", exp_res.closed, closed);
        errors++;
      end
      if (st !== exp_res.st) begin
        $error("station_state: expected %0d, actual %0d", exp_res.st, st);
        errors++;
      end
    endfunction
  endclass

endpackage

/* sim/ev_charge_pilot_state_machine_test.sv */
// Test bench top level: drives pilot ticks and register writes, checks every result beat.
`timescale 1ns / 1ps

module ev_charge_pilot_state_machine_test;
  import evcp_pkg::*;
  import evcp_check_pkg::*;

  // Generous bound: even with the longest gaps and stalls on every beat the
  // run stays well inside it.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned NumPhases = 12;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  // When clear, neither side inserts gaps or stalls.
  bit                  idle_on;
  int unsigned         cycles;
  int unsigned         settings_used;
  logic [TimeW-1:0]    clock_ms;
  pilot_t              prev_lvl;

  pilot_scoreboard     sb;

  evcp_in_if  in_ch ();
  evcp_out_if out_ch ();

  ev_charge_pilot_state_machine dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Every input starts at a known value; the tracker exists before any edge.
  initial begin
    sb = new();
    idle_on = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.pilot_level = '0;
    in_ch.cable_limit = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgMaxAmps;
    cfg_wdata = '0;
  end

  // Watchdog. A hang anywhere ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side back-pressure: ready drops for bursts of random length,
  // separated by runs of random length, and stays high once idling is off.
  initial begin : ready_driver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
      end
    end
  end

  // Monitor. The result checked at an edge always belongs to an earlier tick,
  // so the output beat is checked before the input beat of the same edge is
  // noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.duty_percent, out_ch.contactor_closed, out_ch.station_state);
      if (in_ch.valid && in_ch.ready)
        sb.note_tick(in_ch.pilot_level, in_ch.cable_limit, in_ch.now_ms);
    end
  end

  // Offers one tick and returns at the edge that takes the beat. Valid stays
  // high into the next call unless that call starts with a gap.
  task automatic send_tick(pilot_t lvl, cable_t cable, logic [TimeW-1:0] now);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pilot_level <= lvl;
    in_ch.cable_limit <= cable;
    in_ch.now_ms <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering ticks and waits until every expected result is back, then
  // lets the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_register(idx, data);
  endtask

  // One random tick. In low-rate mode the levels favor 6V and 3V so the
  // session stays in C or D while the low-rate timer runs, and the time
  // steps are scaled to the timeout so that it both fires and does not.
  task automatic random_tick(bit low_mode);
    int unsigned pick;
    int unsigned step_max;
    pilot_t      lvl;
    cable_t      cable;
    logic [TimeW-1:0] now;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      lvl = prev_lvl;
    end else begin
      pick = $urandom_range(0, 99);
      if (low_mode) begin
        if (pick < 40) lvl = PilotLv6;
        else if (pick < 70) lvl = PilotLv3;
        else if (pick < 80) lvl = PilotLv9;
        else if (pick < 90) lvl = PilotLv12;
        else lvl = pilot_t'($urandom_range(4, 7));
      end else begin
        if (pick < 88) lvl = pilot_t'($urandom_range(0, 3));
        else lvl = pilot_t'($urandom_range(4, 7));
      end
    end
    prev_lvl = lvl;
    cable = cable_t'($urandom_range(0, 3));
    step_max = low_mode ? (sb.timeout_ms / 4 + 2) : 1000;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      now = $urandom;
    end else if (pick < 20 && sb.low_since != '0) begin
      // Right on the timeout boundary: equal does not fire, one more does.
      now = sb.low_since + TimeW'(sb.timeout_ms) + TimeW'($urandom_range(0, 1));
    end else if (pick < 23) begin
      now = '0;
    end else begin
      now = clock_ms + TimeW'($urandom_range(0, step_max));
    end
    clock_ms = now;
    send_tick(lvl, cable, now);
  endtask

  initial begin : stimulus
    int unsigned n_items;
    bit          low_mode;
    logic [AmpsW-1:0]    amps;
    logic [TimeoutW-1:0] tmo;

    // Reset is held low, then released on a falling edge.
    cycles = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset settings: moves out of A into A and B and out of B into B, C
    // and D, indoor ventilation with the contactor held open, and fault codes 4, 5 and 7.
    send_tick(PilotLv12, Cable13A, 32'd0);
    send_tick(PilotLv9, Cable20A, 32'd1);
    send_tick(PilotLv9, cable_t'(2), 32'd2);
    send_tick(PilotLv6, cable_t'(3), 32'd3);
    send_tick(PilotLv3, Cable13A, 32'd4);
    send_tick(pilot_t'(4), Cable20A, 32'd5);
    send_tick(pilot_t'(7), Cable13A, 32'd6);
    send_tick(PilotLv12, Cable13A, 32'd7);
    send_tick(PilotLv9, Cable13A, 32'd8);
    send_tick(PilotLv3, Cable20A, 32'd9);
    send_tick(pilot_t'(5), Cable20A, 32'd10);
    send_tick(PilotLv12, cable_t'(3), 32'd11);
    wait_drained();

    // Outdoor with the highest user limit; upper data bits must be ignored.
    write_reg(CfgOutdoor, 16'hFFFF);
    write_reg(CfgMaxAmps, 16'hFFFF);
    write_reg(CfgTimeout, 16'h0000);
    settings_used++;
    send_tick(PilotLv9, cable_t'(2), 32'd100);
    send_tick(PilotLv3, cable_t'(2), 32'd101);
    send_tick(PilotLv3, cable_t'(3), 32'd102);
    send_tick(PilotLv6, cable_t'(3), 32'd103);
    wait_drained();

    // Low duty while charging with a zero timeout. A timer started at time
    // zero stays idle, a start at the top of the range must wrap, and an
    // elapsed time equal to the timeout does not yet fire.
    write_reg(CfgMaxAmps, 16'hFF00);
    settings_used++;
    send_tick(PilotLv6, Cable20A, 32'd0);
    send_tick(PilotLv6, Cable13A, 32'd0);
    send_tick(PilotLv3, Cable13A, 32'hFFFF_FFFF);
    send_tick(PilotLv3, cable_t'(2), 32'hFFFF_FFFF);
    send_tick(PilotLv6, cable_t'(2), 32'd0);
    send_tick(PilotLv9, Cable20A, 32'd5);
    send_tick(PilotLv12, cable_t'(3), 32'd6);

    // Random phases, each with its own register settings. Every third phase
    // runs with a user limit under 6 A; it is preceded by a plug-in sequence
    // at the previous setting so that it starts in state C.
    clock_ms = 32'hFFFF_0000;
    prev_lvl = PilotLv12;
    for (int unsigned p = 0; p < NumPhases; p++) begin
      low_mode = (p % 3 == 2);
      if (p >= NumPhases - 2) idle_on = 1'b0;
      if (low_mode) begin
        send_tick(PilotLv12, cable_t'($urandom_range(0, 3)), clock_ms);
        send_tick(PilotLv9, cable_t'($urandom_range(0, 3)), clock_ms);
        send_tick(PilotLv6, cable_t'($urandom_range(0, 3)), clock_ms);
        send_tick(PilotLv6, cable_t'($urandom_range(0, 3)), clock_ms);
        prev_lvl = PilotLv6;
      end
      wait_drained();
      case (p)
        0: amps = 8'd255;
        1: amps = 8'd6;
        2: amps = 8'd0;
        3: amps = 8'd13;
        4: amps = 8'd20;
        5: amps = 8'd5;
        6: amps = 8'd32;
        7: amps = 8'd21;
        8, 11: amps = AmpsW'($urandom_range(0, 5));
        default: amps = AmpsW'($urandom_range(6, 255));
      endcase
      case (p)
        2: tmo = 16'd0;
        5: tmo = 16'hFFFF;
        8: tmo = TimeoutW'($urandom_range(1, 60));
        11: tmo = TimeoutW'($urandom_range(200, 4000));
        default: tmo = TimeoutW'($urandom);
      endcase
      write_reg(CfgMaxAmps, {(CfgDataW-AmpsW)'($urandom), amps});
      write_reg(CfgOutdoor, {(CfgDataW-1)'($urandom), 1'(p % 2)});
      write_reg(CfgTimeout, tmo);
      write_reg(CfgUnused, CfgDataW'($urandom));
      settings_used++;
      n_items = low_mode ? 40 : 120;
      for (int unsigned i = 0; i < n_items; i++) random_tick(low_mode);
    end
    wait_drained();

    $display("Covered %0d ticks under %0d register settings; low-rate timer fired %0d times.",
             sb.ticks, settings_used, sb.expiries);
    $display("Results per state: A %0d, B %0d, C %0d, D %0d, F %0d.",
             sb.per_state[0], sb.per_state[1], sb.per_state[2], sb.per_state[3],
             sb.per_state[4]);
    if (sb.expected_q.size() != 0) begin
      $error("%0d ticks never produced a result", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/evcp_pkg.sv
hw/rtl/evcp_in_if.sv
hw/rtl/evcp_out_if.sv
hw/rtl/ev_charge_pilot_state_machine.sv
sim/evcp_check_pkg.sv
sim/ev_charge_pilot_state_machine_test.sv
